// ===== src/kdq_pkg.sv =====
`default_nettype none

package kdq_pkg;

  typedef logic [2:0] req_t;
  typedef logic [1:0] status_t;

  localparam req_t REQ_PUSH_BACK  = 3'd0;
  localparam req_t REQ_PUSH_FRONT = 3'd1;
  localparam req_t REQ_POP_FRONT  = 3'd2;
  localparam req_t REQ_POP_BACK   = 3'd3;
  localparam req_t REQ_FIND       = 3'd4;
  localparam req_t REQ_UPDATE     = 3'd5;
  localparam req_t REQ_FIND_MAX   = 3'd6;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

endpackage

`default_nettype wire

// ===== src/kdq_if.sv =====
`default_nettype none

interface kdq_req_if #(
  parameter int KEY_WIDTH   = 16,
  parameter int VALUE_WIDTH = 20
);
  import kdq_pkg::*;

  logic                   valid;
  logic                   ready;
  req_t                   req_type;
  logic [KEY_WIDTH-1:0]   item_key;
  logic [VALUE_WIDTH-1:0] item_value;

  modport source (output valid, output req_type, output item_key, output item_value,
                  input ready);
  modport sink   (input valid, input req_type, input item_key, input item_value,
                  output ready);
endinterface

interface kdq_rsp_if #(
  parameter int KEY_WIDTH   = 16,
  parameter int VALUE_WIDTH = 20,
  parameter int COUNT_WIDTH = 5
);
  import kdq_pkg::*;

  logic                   valid;
  logic                   ready;
  status_t                status;
  logic [KEY_WIDTH-1:0]   out_key;
  logic [VALUE_WIDTH-1:0] out_value;
  logic [VALUE_WIDTH-1:0] prior_value;
  logic [COUNT_WIDTH-1:0] entry_count;

  modport source (output valid, output status, output out_key, output out_value,
                  output prior_value, output entry_count, input ready);
  modport sink   (input valid, input status, input out_key, input out_value,
                  input prior_value, input entry_count, output ready);
endinterface

`default_nettype wire

// ===== src/keyed_double_ended_queue_top.sv =====
// Flow: an accepted beat passes through execute to the result state; pops add a
//   state that captures the RAM read data; find, update and find max scan the entries.
// Throughput: one request at a time, a new beat taken once the previous result
//   is handed to the output register; scans read one entry per cycle through the
//   read port of the entry RAM.
// Reset: synchronous rst empties the queue; stored entries are left as they are.
`default_nettype none

module keyed_double_ended_queue_top #(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 16,
  parameter int VALUE_WIDTH = 20
) (
  input  wire logic clk,
  input  wire logic rst,
  kdq_req_if.sink   req,
  kdq_rsp_if.source rsp
);
  import kdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = KEY_WIDTH + VALUE_WIDTH;

  logic                   res_valid;
  logic                   res_ready;
  status_t                res_status;
  logic [KEY_WIDTH-1:0]   res_key;
  logic [VALUE_WIDTH-1:0] res_value;
  logic [VALUE_WIDTH-1:0] res_prior;
  logic [CW-1:0]          res_count;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [EW-1:0]          mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic [EW-1:0]          mem_rdata;

  kdq_ctrl #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_status (res_status),
    .res_key    (res_key),
    .res_value  (res_value),
    .res_prior  (res_prior),
    .res_count  (res_count),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  kdq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp.status      <= res_status;
      rsp.out_key     <= res_key;
      rsp.out_value   <= res_value;
      rsp.prior_value <= res_prior;
      rsp.entry_count <= res_count;
    end
  end

endmodule

`default_nettype wire

// ===== src/kdq_ram.sv =====
`default_nettype none

module kdq_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/kdq_ctrl.sv =====
`default_nettype none

module kdq_ctrl #(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 16,
  parameter int VALUE_WIDTH = 20,
  parameter int AW          = $clog2(DEPTH),
  parameter int CW          = $clog2(DEPTH + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  kdq_req_if.sink                               req,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output kdq_pkg::status_t                      res_status,
  output logic [KEY_WIDTH-1:0]                  res_key,
  output logic [VALUE_WIDTH-1:0]                res_value,
  output logic [VALUE_WIDTH-1:0]                res_prior,
  output logic [CW-1:0]                         res_count,
  output logic                                  mem_we,
  output logic [AW-1:0]                         mem_waddr,
  output logic [KEY_WIDTH+VALUE_WIDTH-1:0]      mem_wdata,
  output logic                                  mem_re,
  output logic [AW-1:0]                         mem_raddr,
  input  wire logic [KEY_WIDTH+VALUE_WIDTH-1:0] mem_rdata
);
  import kdq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s[AW-1:0];
  endfunction

  logic [2:0]             state;
  logic [AW-1:0]          front;
  logic [CW-1:0]          count;
  req_t                   op;
  logic [KEY_WIDTH-1:0]   key;
  logic [VALUE_WIDTH-1:0] val;
  logic [CW-1:0]          scan_off;
  logic [AW-1:0]          rd_addr;
  logic [KEY_WIDTH-1:0]   best_key;
  logic [VALUE_WIDTH-1:0] best_val;

  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [CW-1:0]          cnt_m1;
  logic                   full;
  logic                   empty;
  logic                   is_search;
  logic                   hit;
  logic                   last;
  logic                   take;
  logic                   scan_more;
  logic [AW-1:0]          front_dec;
  logic [AW-1:0]          pos_first;
  logic [AW-1:0]          pos_back;
  logic [AW-1:0]          pos_push;
  logic [AW-1:0]          pos_next;
  logic [AW-1:0]          pos_pop;

  assign rd_key    = mem_rdata[KEY_WIDTH+VALUE_WIDTH-1:VALUE_WIDTH];
  assign rd_val    = mem_rdata[VALUE_WIDTH-1:0];
  assign cnt_m1    = count - CW'(1);
  assign full      = (count == DEPTH_C);
  assign empty     = (count == '0);
  assign is_search = (op == REQ_FIND) || (op == REQ_UPDATE);
  assign hit       = is_search && (rd_key == key);
  assign last      = (scan_off == count);
  assign take      = (scan_off == CW'(1)) || (rd_val > best_val);
  assign scan_more = (state == S_SCAN) && !last && !hit;
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign pos_first = front;
  assign pos_back  = ring_pos(front, cnt_m1[AW-1:0]);
  assign pos_push  = ring_pos(front, count[AW-1:0]);
  assign pos_next  = ring_pos(front, scan_off[AW-1:0]);
  assign pos_pop   = (op == REQ_POP_FRONT) ? front : pos_back;

  assign req.ready = (state == S_IDLE);
  assign res_valid = (state == S_RESP);
  assign res_count = count;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_push;
    mem_wdata = {key, val};
    mem_re    = 1'b0;
    mem_raddr = pos_first;
    unique case (state)
      S_EXEC: begin
        case (op) inside
          REQ_PUSH_BACK: begin
            mem_we = !full;
          end
          REQ_PUSH_FRONT: begin
            mem_we    = !full;
            mem_waddr = front_dec;
          end
          REQ_POP_FRONT, REQ_POP_BACK: begin
            mem_re    = !empty;
            mem_raddr = pos_pop;
          end
          REQ_FIND, REQ_UPDATE, REQ_FIND_MAX: begin
            mem_re = !empty;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        mem_we    = hit && (op == REQ_UPDATE);
        mem_waddr = rd_addr;
        mem_wdata = {rd_key, val};
        mem_re    = scan_more;
        mem_raddr = pos_next;
      end
      S_IDLE, S_POP, S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op    <= req.req_type;
            key   <= req.item_key;
            val   <= req.item_value;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status <= ST_OK;
          res_key    <= '0;
          res_value  <= '0;
          res_prior  <= '0;
          state      <= S_RESP;
          case (op) inside
            REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                count <= count + CW'(1);
                if (op == REQ_PUSH_FRONT) begin
                  front <= front_dec;
                end
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              if (empty) begin
                res_status <= ST_EMPTY;
              end else begin
                count <= cnt_m1;
                if (op == REQ_POP_FRONT) begin
                  front <= ring_pos(front, AW'(1));
                end
                state <= S_POP;
              end
            end
            REQ_FIND, REQ_UPDATE, REQ_FIND_MAX: begin
              if (empty) begin
                res_status <= (op == REQ_FIND_MAX) ? ST_EMPTY : ST_NOT_FOUND;
              end else begin
                scan_off <= CW'(1);
                rd_addr  <= pos_first;
                state    <= S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
        S_POP: begin
          res_key   <= rd_key;
          res_value <= rd_val;
          state     <= S_RESP;
        end
        S_SCAN: begin
          if (is_search) begin
            if (hit) begin
              res_key <= rd_key;
              if (op == REQ_UPDATE) begin
                res_value <= val;
                res_prior <= rd_val;
              end else begin
                res_value <= rd_val;
              end
              state <= S_RESP;
            end else if (last) begin
              res_status <= ST_NOT_FOUND;
              state      <= S_RESP;
            end
          end else begin
            if (take) begin
              best_key <= rd_key;
              best_val <= rd_val;
            end
            if (last) begin
              res_key   <= take ? rd_key : best_key;
              res_value <= take ? rd_val : best_val;
              state     <= S_RESP;
            end
          end
          if (scan_more) begin
            scan_off <= scan_off + CW'(1);
            rd_addr  <= pos_next;
          end
        end
        S_RESP: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_EXEC))
    else $error("accepted beat did not start execution");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && (op == REQ_PUSH_BACK || op == REQ_PUSH_FRONT) && !full)
    |=> (count == $past(count) + CW'(1)))
    else $error("push did not grow the count");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_off != '0 && scan_off <= count))
    else $error("scan offset out of range");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == S_EXEC && !full) || (state == S_SCAN && op == REQ_UPDATE)))
    else $error("memory write outside push or update");

endmodule

`default_nettype wire

// ===== tb/keyed_double_ended_queue_top_tb.sv =====
`timescale 1ns / 1ps

module keyed_double_ended_queue_top_tb;
  import kdq_pkg::*;

  localparam int DEPTH   = 16;
  localparam int KEY_W   = 16;
  localparam int VAL_W   = 20;
  localparam int COUNT_W = 5;

  localparam req_t REQ_UNUSED = 3'd7;

  localparam int DIRECTED_BEATS = 22;
  localparam int RANDOM_BEATS   = 820;
  localparam int HOLD_OFF_AFTER = 300;
  localparam int HOLD_OFF_LEN   = 400;

  typedef struct packed {
    req_t             op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } kdq_req_s;

  typedef struct packed {
    status_t            status;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [VAL_W-1:0]   prior;
    logic [COUNT_W-1:0] count;
  } kdq_rsp_s;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_e;

  logic clk;
  logic rst = 1'b1;

  kdq_req_if #(.KEY_WIDTH(KEY_W), .VALUE_WIDTH(VAL_W)) req_bus ();
  kdq_rsp_if #(.KEY_WIDTH(KEY_W), .VALUE_WIDTH(VAL_W), .COUNT_WIDTH(COUNT_W)) rsp_bus ();

  keyed_double_ended_queue_top #(
    .DEPTH(DEPTH),
    .KEY_WIDTH(KEY_W),
    .VALUE_WIDTH(VAL_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // stimulus and scoreboard storage
  kdq_req_s       outgoing_reqs[$];
  kdq_rsp_s       awaited_rsps[$];
  int             planned_level;
  logic [KEY_W-1:0] key_pool[6];
  logic [VAL_W-1:0] value_pool[5];

  // mirror of the queue contents
  logic [KEY_W-1:0] mirror_keys[DEPTH];
  logic [VAL_W-1:0] mirror_values[DEPTH];
  int               head_slot;
  int               fill_level;

  int       errors;
  int       accepted_beats;
  bit       req_beat_taken;
  logic     hold_off = 1'b0;
  int       burst_left;
  int       gap_left;
  int       rx_phase;
  rx_mode_e rx_mode = RX_OPEN;
  kdq_req_s next_beat;
  kdq_rsp_s got_rsp;
  kdq_rsp_s want_rsp;

  function automatic kdq_rsp_s deque_predict(kdq_req_s r);
    kdq_rsp_s o;
    int       slot;
    int       hit;
    int       i;
    o   = '0;
    hit = -1;
    case (r.op)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (fill_level == DEPTH) begin
          o.status = ST_FULL;
        end else begin
          if (r.op == REQ_PUSH_BACK) begin
            slot = (head_slot + fill_level) % DEPTH;
          end else begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            slot      = head_slot;
          end
          mirror_keys[slot]   = r.key;
          mirror_values[slot] = r.value;
          fill_level++;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (fill_level == 0) begin
          o.status = ST_EMPTY;
        end else begin
          slot = (r.op == REQ_POP_FRONT) ? head_slot : (head_slot + fill_level - 1) % DEPTH;
          o.key   = mirror_keys[slot];
          o.value = mirror_values[slot];
          if (r.op == REQ_POP_FRONT) head_slot = (head_slot + 1) % DEPTH;
          fill_level--;
        end
      end
      REQ_FIND, REQ_UPDATE: begin
        for (i = 0; i < fill_level && hit < 0; i++) begin
          slot = (head_slot + i) % DEPTH;
          if (mirror_keys[slot] == r.key) hit = slot;
        end
        if (hit < 0) begin
          o.status = ST_NOT_FOUND;
        end else begin
          o.key = mirror_keys[hit];
          if (r.op == REQ_UPDATE) begin
            o.prior            = mirror_values[hit];
            mirror_values[hit] = r.value;
          end
          o.value = mirror_values[hit];
        end
      end
      REQ_FIND_MAX: begin
        if (fill_level == 0) begin
          o.status = ST_EMPTY;
        end else begin
          hit = head_slot;
          for (i = 1; i < fill_level; i++) begin
            slot = (head_slot + i) % DEPTH;
            if (mirror_values[slot] > mirror_values[hit]) hit = slot;
          end
          o.key   = mirror_keys[hit];
          o.value = mirror_values[hit];
        end
      end
      default: ;
    endcase
    o.count = COUNT_W'(fill_level);
    return o;
  endfunction

  function automatic void stage_request(req_t op, logic [KEY_W-1:0] key,
                                        logic [VAL_W-1:0] value);
    kdq_req_s r;
    r.op    = op;
    r.key   = key;
    r.value = value;
    outgoing_reqs.push_back(r);
    if ((op == REQ_PUSH_BACK || op == REQ_PUSH_FRONT) && planned_level < DEPTH)
      planned_level++;
    if ((op == REQ_POP_FRONT || op == REQ_POP_BACK) && planned_level > 0)
      planned_level--;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, 5)];
    return KEY_W'($urandom());
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 3) == 0) return value_pool[$urandom_range(0, 4)];
    return VAL_W'($urandom());
  endfunction

  function automatic req_t pick_any_op();
    if ($urandom_range(0, 49) == 0) return REQ_UNUSED;
    return req_t'($urandom_range(REQ_PUSH_BACK, REQ_FIND_MAX));
  endfunction

  function automatic req_t pick_non_push_op();
    if ($urandom_range(0, 49) == 0) return REQ_UNUSED;
    return req_t'($urandom_range(REQ_POP_FRONT, REQ_FIND_MAX));
  endfunction

  function automatic req_t pick_non_pop_op();
    case ($urandom_range(0, 4))
      0: return REQ_PUSH_BACK;
      1: return REQ_PUSH_FRONT;
      2: return REQ_FIND;
      3: return REQ_UPDATE;
      default: return REQ_FIND_MAX;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_beat_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        req_bus.valid <= 1'b0;
      end else if (outgoing_reqs.size() != 0) begin
        next_beat = outgoing_reqs.pop_front();
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= next_beat.op;
        req_bus.item_key   <= next_beat.key;
        req_bus.item_value <= next_beat.value;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // response receiver
  always @(negedge clk) begin
    rx_phase++;
    if (rx_phase % 48 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:    rsp_bus.ready <= !hold_off;
      RX_COIN:    rsp_bus.ready <= !hold_off && ($urandom_range(0, 1) == 1);
      RX_SPARSE:  rsp_bus.ready <= !hold_off && ($urandom_range(0, 4) == 0);
      RX_PATTERN: rsp_bus.ready <= !hold_off && (rx_phase % 8 != 7);
      default:    rsp_bus.ready <= !hold_off;
    endcase
  end

  // monitor and checker
  always @(posedge clk) begin
    req_beat_taken = !rst && req_bus.valid && req_bus.ready;
    if (req_beat_taken) begin
      next_beat.op    = req_bus.req_type;
      next_beat.key   = req_bus.item_key;
      next_beat.value = req_bus.item_value;
      awaited_rsps.push_back(deque_predict(next_beat));
      accepted_beats++;
    end
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got_rsp.status = rsp_bus.status;
      got_rsp.key    = rsp_bus.out_key;
      got_rsp.value  = rsp_bus.out_value;
      got_rsp.prior  = rsp_bus.prior_value;
      got_rsp.count  = rsp_bus.entry_count;
      if (awaited_rsps.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got_rsp);
      end else begin
        want_rsp = awaited_rsps.pop_front();
        check_field("status", VAL_W'(want_rsp.status), VAL_W'(got_rsp.status));
        check_field("out_key", VAL_W'(want_rsp.key), VAL_W'(got_rsp.key));
        check_field("out_value", want_rsp.value, got_rsp.value);
        check_field("prior_value", want_rsp.prior, got_rsp.prior);
        check_field("entry_count", VAL_W'(want_rsp.count), VAL_W'(got_rsp.count));
      end
    end
  end

  // hold the receiver off long enough to back up the request side
  initial begin
    do @(negedge clk); while (accepted_beats < HOLD_OFF_AFTER);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_LEN) @(negedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("keyed_double_ended_queue_top_tb: done, errors");
    $finish;
  end

  initial begin
    int overflow;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = REQ_PUSH_BACK;
    req_bus.item_key   = '0;
    req_bus.item_value = '0;
    rsp_bus.ready      = 1'b0;
    errors         = 0;
    accepted_beats = 0;
    req_beat_taken = 1'b0;
    burst_left     = 0;
    gap_left       = 0;
    rx_phase       = 0;
    head_slot      = 0;
    fill_level     = 0;
    planned_level  = 0;
    key_pool   = '{16'h0000, 16'hFFFF, 16'h1234, KEY_W'($urandom()),
                   KEY_W'($urandom()), KEY_W'($urandom())};
    value_pool = '{20'h00000, 20'hFFFFF, 20'hFFFFE, 20'h00001, 20'h80000};

    // empty queue corners
    stage_request(REQ_POP_FRONT, 16'h0000, 20'h00000);
    stage_request(REQ_POP_BACK, 16'hFFFF, 20'hFFFFF);
    stage_request(REQ_FIND_MAX, 16'h0000, 20'h00000);
    stage_request(REQ_FIND, 16'h0000, 20'h00000);
    stage_request(REQ_UPDATE, 16'h0000, 20'h12345);
    stage_request(REQ_UNUSED, 16'hFFFF, 20'hFFFFF);
    // extremes, ties for the maximum, duplicate keys
    stage_request(REQ_PUSH_BACK, 16'hFFFF, 20'hFFFFF);
    stage_request(REQ_PUSH_FRONT, 16'h0000, 20'h00000);
    stage_request(REQ_PUSH_BACK, 16'h1234, 20'hFFFFF);
    stage_request(REQ_FIND_MAX, 16'h0000, 20'h00000);
    stage_request(REQ_FIND, 16'h1234, 20'h00000);
    stage_request(REQ_FIND, 16'hFFFF, 20'h00000);
    stage_request(REQ_UPDATE, 16'h1234, 20'h00005);
    stage_request(REQ_FIND, 16'hBEEF, 20'h00000);
    stage_request(REQ_UPDATE, 16'hBEEF, 20'h00007);
    stage_request(REQ_PUSH_FRONT, 16'h1234, 20'h00007);
    stage_request(REQ_FIND, 16'h1234, 20'h00000);
    stage_request(REQ_UPDATE, 16'h1234, 20'hFFFFF);
    stage_request(REQ_FIND_MAX, 16'h0000, 20'h00000);
    stage_request(REQ_POP_BACK, 16'h0000, 20'h00000);
    stage_request(REQ_POP_FRONT, 16'h0000, 20'h00000);
    stage_request(REQ_UNUSED, 16'h0000, 20'h00000);

    // rounds of fill to full, mixed traffic, drain to empty
    while (outgoing_reqs.size() < DIRECTED_BEATS + RANDOM_BEATS) begin
      overflow = $urandom_range(0, 3);
      while (planned_level < DEPTH || overflow > 0) begin
        if (planned_level == DEPTH) overflow--;
        if ($urandom_range(0, 9) < 6)
          stage_request(req_t'($urandom_range(REQ_PUSH_BACK, REQ_PUSH_FRONT)),
                        pick_key(), pick_value());
        else
          stage_request(pick_non_push_op(), pick_key(), pick_value());
      end
      repeat ($urandom_range(10, 40)) stage_request(pick_any_op(), pick_key(), pick_value());
      overflow = $urandom_range(0, 3);
      while (planned_level > 0 || overflow > 0) begin
        if (planned_level == 0) overflow--;
        if ($urandom_range(0, 9) < 6)
          stage_request(req_t'($urandom_range(REQ_POP_FRONT, REQ_POP_BACK)),
                        pick_key(), pick_value());
        else
          stage_request(pick_non_pop_op(), pick_key(), pick_value());
      end
      repeat ($urandom_range(10, 40)) stage_request(pick_any_op(), pick_key(), pick_value());
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (outgoing_reqs.size() != 0 || req_bus.valid);
    do @(negedge clk); while (awaited_rsps.size() != 0);
    repeat (DEPTH + 10) @(posedge clk);

    if (errors == 0)
      $display("keyed_double_ended_queue_top_tb: done, clean");
    else
      $display("keyed_double_ended_queue_top_tb: done, errors");
    $finish;
  end

endmodule
